>>> rtl/toun_pkg.sv
// ---------------------------------------------------------------------------
// toun_pkg
// Shared types and constants of the triangle oriented unit normal core.
// ---------------------------------------------------------------------------
package toun_pkg;

    localparam int CB  = 16;          // coordinate width, signed q4.12
    localparam int NF  = 14;          // normal fraction bits
    localparam int OB  = NF + 2;      // normal output width, signed q1.14
    localparam int MB  = 30;          // scaled magnitude width

    // register indexes
    localparam logic [1:0] REG_REF_X = 2'd0;
    localparam logic [1:0] REG_REF_Y = 2'd1;
    localparam logic [1:0] REG_REF_Z = 2'd2;

    localparam logic signed [CB-1:0] REF_X_RST = 16'sd0;
    localparam logic signed [CB-1:0] REF_Y_RST = 16'sd0;
    localparam logic signed [CB-1:0] REF_Z_RST = 16'sd2048;

    typedef struct packed {
        logic signed [CB-1:0] ax;
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] az;
        logic signed [CB-1:0] bx;
        logic signed [CB-1:0] by;
        logic signed [CB-1:0] bz;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic signed [CB-1:0] cz;
    } t_tri_in;

    typedef struct packed {
        logic                 swapped;
        logic signed [OB-1:0] normal_x;
        logic signed [OB-1:0] normal_y;
        logic signed [OB-1:0] normal_z;
        logic                 degenerate;
    } t_norm_out;

    // classified triangle handed from front to back
    typedef struct packed {
        logic                  swapped;
        logic                  degenerate;
        logic [2:0]            neg;
        logic [2:0][MB-1:0]    m;
    } t_item;

endpackage

>>> rtl/toun_front.sv
// ---------------------------------------------------------------------------
// toun_front
// Edge vectors, cross product, orientation test and magnitude scaling.
// ---------------------------------------------------------------------------
module toun_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  toun_pkg::t_tri_in           i_tri,
    input  logic [2:0][toun_pkg::CB-1:0] i_ref,
    input  logic                        i_q_full,
    output logic                        o_push,
    output toun_pkg::t_item             o_item
);
    import toun_pkg::*;

    localparam int EB = CB + 1;       // edge width
    localparam int DB = CB + 3;       // centroid direction width
    localparam int NB = 2 * EB + 1;   // cross term width
    localparam int PB = NB + DB + 2;  // dot width

    logic [5:0] r_v;
    logic       f_en;

    // stage 1
    logic signed [EB-1:0] r_e1 [3], r_e2 [3], n_e1 [3], n_e2 [3];
    logic signed [DB-1:0] r_d1 [3], n_d1 [3];
    // stage 2
    logic signed [NB-1:0] r_n2 [3], n_n2 [3];
    logic signed [DB-1:0] r_d2 [3];
    // stage 3
    logic signed [NB-1:0] r_n3 [3];
    logic signed [PB-1:0] r_p3 [3], n_p3 [3];
    // stage 4
    logic                 r_sw4, r_dg4, n_sw4, n_dg4;
    logic [2:0]           r_ng4, n_ng4;
    logic [NB-1:0]        r_mg4 [3], n_mg4 [3];
    // stage 5
    logic                 r_sw5, r_dg5;
    logic [2:0]           r_ng5;
    logic [NB-1:0]        r_mg5 [3];
    logic [5:0]           r_top5, n_top5;
    // stage 6
    t_item                r_it6, n_it6;

    logic signed [CB-1:0] va [3], vb [3], vc [3];
    logic signed [PB-1:0] dot;
    logic signed [NB-1:0] on;
    logic [NB-1:0]        orv;

    // stages move together while the queue can take the last one
    assign f_en    = !(r_v[5] && i_q_full);
    assign o_stall = !f_en;
    assign o_push  = r_v[5] && f_en;
    assign o_item  = r_it6;

    // stage 1: edges and centroid direction
    always_comb begin
        va[0] = i_tri.ax; va[1] = i_tri.ay; va[2] = i_tri.az;
        vb[0] = i_tri.bx; vb[1] = i_tri.by; vb[2] = i_tri.bz;
        vc[0] = i_tri.cx; vc[1] = i_tri.cy; vc[2] = i_tri.cz;
        for (int i = 0; i < 3; i++) begin
            n_e1[i] = EB'(vb[i]) - EB'(va[i]);
            n_e2[i] = EB'(vc[i]) - EB'(va[i]);
            n_d1[i] = DB'(va[i]) + DB'(vb[i]) + DB'(vc[i])
                    - DB'($signed(i_ref[i])) * DB'(3);
        end
    end

    // stage 2: cross product
    always_comb begin
        n_n2[0] = NB'(r_e1[1]) * NB'(r_e2[2]) - NB'(r_e1[2]) * NB'(r_e2[1]);
        n_n2[1] = NB'(r_e1[2]) * NB'(r_e2[0]) - NB'(r_e1[0]) * NB'(r_e2[2]);
        n_n2[2] = NB'(r_e1[0]) * NB'(r_e2[1]) - NB'(r_e1[1]) * NB'(r_e2[0]);
    end

    // stage 3: dot partial products
    always_comb begin
        for (int i = 0; i < 3; i++)
            n_p3[i] = PB'(r_n2[i]) * PB'(r_d2[i]);
    end

    // stage 4: orientation, sign and magnitude
    always_comb begin
        dot   = r_p3[0] + r_p3[1] + r_p3[2];
        n_sw4 = (dot <= 0);
        n_dg4 = (r_n3[0] == '0) && (r_n3[1] == '0) && (r_n3[2] == '0);
        for (int i = 0; i < 3; i++) begin
            on        = n_sw4 ? -r_n3[i] : r_n3[i];
            n_ng4[i]  = on[NB-1];
            n_mg4[i]  = on[NB-1] ? NB'(-on) : NB'(on);
        end
    end

    // stage 5: bit length of the largest magnitude
    always_comb begin
        orv    = r_mg4[0] | r_mg4[1] | r_mg4[2];
        n_top5 = '0;
        for (int i = 0; i < NB; i++)
            if (orv[i]) n_top5 = 6'(i + 1);
    end

    // stage 6: common power-of-two scaling
    always_comb begin
        n_it6.swapped    = r_sw5;
        n_it6.degenerate = r_dg5;
        n_it6.neg        = r_ng5;
        for (int i = 0; i < 3; i++) begin
            if (r_top5 > 6'(MB))
                n_it6.m[i] = MB'(r_mg5[i] >> (r_top5 - 6'(MB)));
            else
                n_it6.m[i] = MB'(r_mg5[i] << (6'(MB) - r_top5));
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (f_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_e1   <= n_e1;
            r_e2   <= n_e2;
            r_d1   <= n_d1;
            r_n2   <= n_n2;
            r_d2   <= r_d1;
            r_n3   <= r_n2;
            r_p3   <= n_p3;
            r_sw4  <= n_sw4;
            r_dg4  <= n_dg4;
            r_ng4  <= n_ng4;
            r_mg4  <= n_mg4;
            r_sw5  <= r_sw4;
            r_dg5  <= r_dg4;
            r_ng5  <= r_ng4;
            r_mg5  <= r_mg4;
            r_top5 <= n_top5;
            r_it6  <= n_it6;
        end
    end

endmodule

>>> rtl/toun_queue.sv
// ---------------------------------------------------------------------------
// toun_queue
// Short fifo between the classifying front and the normalizing back.
// ---------------------------------------------------------------------------
module toun_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  toun_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_full,
    output toun_pkg::t_item o_item
);
    import toun_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_item         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_item  = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

>>> rtl/toun_back.sv
// ---------------------------------------------------------------------------
// toun_back
// Squares, pipelined integer square root, rounded division and output stage.
// ---------------------------------------------------------------------------
module toun_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  toun_pkg::t_item     i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output toun_pkg::t_norm_out o_norm
);
    import toun_pkg::*;

    localparam int SB  = 2 * MB + 2;     // sum of squares width
    localparam int NRT = SB / 2 + 1;     // root steps
    localparam int RB  = MB + 1;         // root width
    localparam int NDV = NF + 1;         // quotient bits
    localparam int QB  = NDV;
    localparam int WB  = MB + NF + 2;    // remainder width

    logic b_en;

    logic                  r_sq_v;
    t_item                 r_sq_it;
    logic [2:0][2*MB-1:0]  r_sq;
    logic                  r_sm_v;
    t_item                 r_sm_it;
    logic [SB-1:0]         r_sm;

    logic                  r_rt_v [NRT];
    t_item                 r_rt_it [NRT];
    logic [SB-1:0]         r_rt_x [NRT], n_rt_x [NRT];
    logic [63:0]           r_rt_res [NRT], n_rt_res [NRT];

    logic                  r_nm_v;
    t_item                 r_nm_it;
    logic [RB-1:0]         r_nm_r;
    logic [2:0][WB-1:0]    r_nm_rem;

    logic                  r_dv_v [NDV];
    t_item                 r_dv_it [NDV];
    logic [RB-1:0]         r_dv_r [NDV];
    logic [2:0][WB-1:0]    r_dv_rem [NDV], n_dv_rem [NDV];
    logic [2:0][QB-1:0]    r_dv_q [NDV], n_dv_q [NDV];

    logic                  r_out_v;
    t_norm_out             r_out, n_out;

    logic [63:0]           px, pres, bitv, trial;
    logic [RB-1:0]         rr;
    logic [2:0][WB-1:0]    prem;
    logic [2:0][QB-1:0]    pq;
    logic [WB-1:0]         dsh;
    logic [QB-1:0]         qc;
    logic [OB-1:0]         comp [3];

    // whole back pipeline holds while a result waits
    assign b_en    = !(r_out_v && i_stall);
    assign o_pop   = b_en;
    assign o_valid = r_out_v;
    assign o_norm  = r_out;

    // square root, one result bit per stage
    always_comb begin
        for (int k = 0; k < NRT; k++) begin
            px    = (k == 0) ? 64'(r_sm) : 64'(r_rt_x[k-1]);
            pres  = (k == 0) ? 64'd0 : r_rt_res[k-1];
            bitv  = 64'd1 << (2 * (NRT - 1 - k));
            trial = pres + bitv;
            if (px >= trial) begin
                n_rt_x[k]   = SB'(px - trial);
                n_rt_res[k] = (pres >> 1) + bitv;
            end else begin
                n_rt_x[k]   = SB'(px);
                n_rt_res[k] = pres >> 1;
            end
        end
    end

    // restoring division, one quotient bit per stage for three lanes
    always_comb begin
        for (int j = 0; j < NDV; j++) begin
            rr   = (j == 0) ? r_nm_r : r_dv_r[j-1];
            prem = (j == 0) ? r_nm_rem : r_dv_rem[j-1];
            pq   = (j == 0) ? '0 : r_dv_q[j-1];
            dsh  = WB'(rr) << (NDV - 1 - j);
            for (int i = 0; i < 3; i++) begin
                if (prem[i] >= dsh) begin
                    prem[i]             = prem[i] - dsh;
                    pq[i][NDV - 1 - j]  = 1'b1;
                end
            end
            n_dv_rem[j] = prem;
            n_dv_q[j]   = pq;
        end
    end

    // clamp to one, apply sign, zero a degenerate normal
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qc = r_dv_q[NDV-1][i];
            if (qc > QB'(1 << NF)) qc = QB'(1 << NF);
            comp[i] = r_dv_it[NDV-1].neg[i] ? OB'(-OB'(qc)) : OB'(qc);
            if (r_dv_it[NDV-1].degenerate) comp[i] = '0;
        end
        n_out.swapped    = r_dv_it[NDV-1].swapped;
        n_out.degenerate = r_dv_it[NDV-1].degenerate;
        n_out.normal_x   = comp[0];
        n_out.normal_y   = comp[1];
        n_out.normal_z   = comp[2];
    end

    // valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v  <= 1'b0;
            r_sm_v  <= 1'b0;
            r_nm_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < NRT; k++) r_rt_v[k] <= 1'b0;
            for (int j = 0; j < NDV; j++) r_dv_v[j] <= 1'b0;
        end else if (b_en) begin
            r_sq_v <= !i_q_empty;
            r_sm_v <= r_sq_v;
            r_rt_v[0] <= r_sm_v;
            for (int k = 1; k < NRT; k++) r_rt_v[k] <= r_rt_v[k-1];
            r_nm_v <= r_rt_v[NRT-1];
            r_dv_v[0] <= r_nm_v;
            for (int j = 1; j < NDV; j++) r_dv_v[j] <= r_dv_v[j-1];
            r_out_v <= r_dv_v[NDV-1];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_sq_it <= i_item;
            for (int i = 0; i < 3; i++)
                r_sq[i] <= (2*MB)'(i_item.m[i]) * (2*MB)'(i_item.m[i]);
            r_sm_it <= r_sq_it;
            r_sm    <= SB'(r_sq[0]) + SB'(r_sq[1]) + SB'(r_sq[2]);
            r_rt_it[0] <= r_sm_it;
            for (int k = 1; k < NRT; k++) r_rt_it[k] <= r_rt_it[k-1];
            r_rt_x   <= n_rt_x;
            r_rt_res <= n_rt_res;
            r_nm_it <= r_rt_it[NRT-1];
            r_nm_r  <= RB'(r_rt_res[NRT-1]);
            for (int i = 0; i < 3; i++)
                r_nm_rem[i] <= (WB'(r_rt_it[NRT-1].m[i]) << NF)
                             + WB'(r_rt_res[NRT-1] >> 1);
            r_dv_it[0] <= r_nm_it;
            r_dv_r[0]  <= r_nm_r;
            for (int j = 1; j < NDV; j++) begin
                r_dv_it[j] <= r_dv_it[j-1];
                r_dv_r[j]  <= r_dv_r[j-1];
            end
            r_dv_rem <= n_dv_rem;
            r_dv_q   <= n_dv_q;
            r_out    <= n_out;
        end
    end

endmodule

>>> rtl/triangle_oriented_unit_normal_core.sv
// ---------------------------------------------------------------------------
// triangle_oriented_unit_normal_core
// Outward-oriented unit normal of a triangle against a reference point.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_tri  (t_tri_in)
//   output   out        o_valid / i_stall    o_norm (t_norm_out)
//   config   in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one triangle per cycle sustained while i_stall is low; stages are 6 front,
// the queue, 2 square, 32 root, 1 setup, 15 divide and 1 output.
// the root and divide pipelines set the latency.
// the front stalls only when the 4-entry queue is full; the back holds
// whole while a result waits. synchronous active-low reset.
// ---------------------------------------------------------------------------
module triangle_oriented_unit_normal_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  toun_pkg::t_tri_in       i_tri,
    output logic                    o_valid,
    input  logic                    i_stall,
    output toun_pkg::t_norm_out     o_norm,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [toun_pkg::CB-1:0] i_cfg_data
);
    import toun_pkg::*;

    logic [2:0][CB-1:0] r_ref;
    logic               q_full, q_empty, q_push, q_pop;
    t_item              q_in, q_out;

    // reference point registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref[0] <= REF_X_RST;
            r_ref[1] <= REF_Y_RST;
            r_ref[2] <= REF_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_REF_X: r_ref[0] <= i_cfg_data;
                REG_REF_Y: r_ref[1] <= i_cfg_data;
                REG_REF_Z: r_ref[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    toun_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_tri    (i_tri),
        .i_ref    (r_ref),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (q_in)
    );

    toun_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_item  (q_out)
    );

    toun_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_norm    (o_norm)
    );

endmodule

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the triangle oriented unit normal core. Random and
// directed triangles are streamed in bursts while the output side stalls on
// its own pattern; a scoreboard predicts orientation, degeneracy and the
// q1.14 unit normal of every accepted triangle and checks results in order.
// ---------------------------------------------------------------------------
module tb_top;
    import toun_pkg::*;

    localparam int N_RANDOM  = 1930;
    localparam int LATENCY   = 80;
    localparam int MAX_CYC   = 400000;

    // index past the last register, writes to it are dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // scoreboard: predicts the oriented unit normal of each triangle
    class normal_scoreboard;
        logic signed [CB-1:0] ref_pt [3];
        t_norm_out pending [$];
        int mismatches;
        int checked;

        function void reset_refs();
            ref_pt[0] = REF_X_RST;
            ref_pt[1] = REF_Y_RST;
            ref_pt[2] = REF_Z_RST;
        endfunction

        function void set_ref(logic [1:0] idx, logic [CB-1:0] val);
            if (idx <= REG_REF_Z) ref_pt[idx] = val;
        endfunction

        // integer square root, floor
        function longint unsigned root_floor(longint unsigned x);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        function void note_triangle(t_tri_in t);
            logic signed [127:0] v [9];
            logic signed [127:0] e1 [3], e2 [3], dv [3], nv [3], mag [3];
            logic signed [127:0] dot;
            logic [127:0] sh;
            longint unsigned m [3], s, r, q;
            bit neg [3];
            bit swp, degen;
            int top, k;
            t_norm_out o;
            v[0] = t.ax; v[1] = t.ay; v[2] = t.az;
            v[3] = t.bx; v[4] = t.by; v[5] = t.bz;
            v[6] = t.cx; v[7] = t.cy; v[8] = t.cz;
            for (int i = 0; i < 3; i++) begin
                e1[i] = v[3+i] - v[i];
                e2[i] = v[6+i] - v[i];
                dv[i] = v[i] + v[3+i] + v[6+i] - 3 * 128'(signed'(ref_pt[i]));
            end
            nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
            nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
            nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
            dot = nv[0] * dv[0] + nv[1] * dv[1] + nv[2] * dv[2];
            swp = (dot <= 0);
            degen = (nv[0] == 0) && (nv[1] == 0) && (nv[2] == 0);
            o = '0;
            o.swapped = swp;
            o.degenerate = degen;
            if (!degen) begin
                top = 0;
                for (int i = 0; i < 3; i++) begin
                    if (swp) nv[i] = -nv[i];
                    neg[i] = nv[i] < 0;
                    mag[i] = neg[i] ? -nv[i] : nv[i];
                    for (int b = 0; b < 128; b++)
                        if (mag[i][b]) top = (b + 1 > top) ? b + 1 : top;
                end
                for (int i = 0; i < 3; i++) begin
                    sh = mag[i];
                    if (top > MB) begin
                        k = top - MB;
                        sh = sh >> k;
                    end else begin
                        sh = sh << (MB - top);
                    end
                    m[i] = sh[63:0];
                end
                s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                r = root_floor(s);
                for (int i = 0; i < 3; i++) begin
                    q = (r != 0) ? ((m[i] << NF) + (r >> 1)) / r : 0;
                    if (q > (64'd1 << NF)) q = 64'd1 << NF;
                    q = neg[i] ? -q : q;
                    case (i)
                        0: o.normal_x = q[OB-1:0];
                        1: o.normal_y = q[OB-1:0];
                        default: o.normal_z = q[OB-1:0];
                    endcase
                end
            end
            pending.insert(pending.size(), o);
        endfunction

        function void check_result(t_norm_out got);
            t_norm_out exp_o;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp_o = pending.pop_front();
            checked++;
            if (got !== exp_o) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch #%0d: exp sw=%b n=(%0d,%0d,%0d) dg=%b",
                        checked, exp_o.swapped, exp_o.normal_x, exp_o.normal_y,
                        exp_o.normal_z, exp_o.degenerate);
                    $display(" got sw=%b n=(%0d,%0d,%0d) dg=%b",
                        got.swapped, got.normal_x, got.normal_y, got.normal_z,
                        got.degenerate);
                end
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    t_tri_in     i_tri = '0;
    logic        o_valid;
    logic        i_stall = 0;
    t_norm_out   o_norm;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = REG_REF_X;
    logic [CB-1:0] i_cfg_data = '0;

    normal_scoreboard sb = new();
    int cycle_count = 0;
    int stall_mode = 0;
    int triangles_sent = 0;

    triangle_oriented_unit_normal_core i_dut (.*);

    // clock
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYC) begin
            $display("timeout");
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: stall pattern and checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) sb.check_result(o_norm);
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(3) == 0);
                2: i_stall <= ($urandom_range(1) == 0);
                default: i_stall <= ($urandom_range(7) != 0);
            endcase
            if ($urandom_range(60) == 0) stall_mode <= $urandom_range(3);
        end
    end

    // random coordinate: mostly small, sometimes full range or extreme
    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1, 2, 3: return CB'($urandom);
            default: return 16'($signed($urandom_range(8191)) - 4096);
        endcase
    endfunction

    task automatic send_triangle(t_tri_in t);
        i_valid <= 1'b1;
        i_tri <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_triangle(t);
        triangles_sent++;
    endtask

    task automatic gap();
        i_valid <= 1'b0;
        repeat ($urandom_range(4, 1)) @(posedge i_clk);
    endtask

    task automatic write_ref(logic [1:0] idx, logic [CB-1:0] val);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_ref(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_tri_in tri_of(int ax, int ay, int az, int bx, int by, int bz,
                                       int cx, int cy, int cz);
        t_tri_in t;
        t.ax = CB'(ax); t.ay = CB'(ay); t.az = CB'(az);
        t.bx = CB'(bx); t.by = CB'(by); t.bz = CB'(bz);
        t.cx = CB'(cx); t.cy = CB'(cy); t.cz = CB'(cz);
        return t;
    endfunction

    function automatic t_tri_in rand_tri();
        t_tri_in t;
        t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
        t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
        // sometimes a collinear or repeated vertex
        case ($urandom_range(15))
            0: begin t.bx = t.ax; t.by = t.ay; t.bz = t.az; end
            1: begin t.cx = t.bx; t.cy = t.by; t.cz = t.bz; end
            default: ;
        endcase
        return t;
    endfunction

    // stimulus
    initial begin
        int burst;
        sb.reset_refs();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed triangles under reset reference
        send_triangle(tri_of(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_triangle(tri_of(0, 0, 0, 0, 4096, 0, 4096, 0, 0));
        send_triangle(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(tri_of(100, 200, 300, 100, 200, 300, 5, 6, 7));
        send_triangle(tri_of(0, 0, 0, 4096, 4096, 4096, 8192, 8192, 8192));
        send_triangle(tri_of(-32768, -32768, -32768, 32767, -32768, -32768,
                             -32768, 32767, 32767));
        send_triangle(tri_of(32767, 32767, 32767, -32768, 32767, 32767,
                             32767, -32768, -32768));
        send_triangle(tri_of(-32768, 0, 0, 32767, 0, 0, 0, 0, 32767));
        send_triangle(tri_of(0, 0, 2048, 4096, 0, 2048, 0, 4096, 2048));
        send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_triangle(tri_of(1, 1, 1, 2, 1, 1, 1, 1, 2));
        send_triangle(tri_of(-4096, -4096, 0, 4096, -4096, 0, 0, 4096, 0));
        drain();

        write_ref(REG_REF_X, 16'h7fff);
        write_ref(REG_REF_Y, 16'h8000);
        write_ref(REG_REF_Z, 16'h8000);
        write_ref(REG_UNUSED, 16'h1234);
        send_triangle(tri_of(0, 0, 0, 4096, 0, 0, 0, 4096, 0));
        send_triangle(tri_of(-32768, -32768, -32768, 32767, 32767, -32768,
                             32767, -32768, 32767));
        send_triangle(tri_of(32767, 32767, 32767, 32767, -32768, 32767,
                             -32768, 32767, 32767));

        // random phases with differing reference points
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_ref(REG_REF_X, 16'h0);
                    write_ref(REG_REF_Y, 16'h0);
                    write_ref(REG_REF_Z, 16'd2048);
                end
                1: begin
                    write_ref(REG_REF_X, 16'h8000);
                    write_ref(REG_REF_Y, 16'h7fff);
                    write_ref(REG_REF_Z, 16'h7fff);
                end
                default: begin
                    write_ref(REG_REF_X, CB'($urandom));
                    write_ref(REG_REF_Y, CB'($urandom));
                    write_ref(REG_REF_Z, CB'($urandom));
                end
            endcase
            for (int n = 0; n < N_RANDOM / 6; ) begin
                burst = $urandom_range(40, 1);
                for (int b = 0; b < burst && n < N_RANDOM / 6; b++, n++)
                    send_triangle(rand_tri());
                if ($urandom_range(3) != 0) gap();
            end
        end
        drain();

        $display("%0d triangles checked over directed cases and six reference settings",
                 sb.checked);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
